// ===== src/rvaa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvaa_pkg
// Shared widths, constants and stage payload types of the axis-angle
// rotation datapath.
// ----------------------------------------------------------------------------
package rvaa_pkg;

    localparam int AXIS_W   = 18;
    localparam int POS_W    = 32;
    localparam int OMC_W    = AXIS_W + 1;
    localparam int KOM_W    = AXIS_W + OMC_W - 1;
    localparam int PROD_W   = AXIS_W + POS_W;
    localparam int DOT_W    = PROD_W + 1;
    localparam int DLO_W    = 26;
    localparam int DHI_W    = DOT_W - DLO_W;
    localparam int T1H_W    = KOM_W + DHI_W;
    localparam int T1L_W    = KOM_W + DLO_W + 1;
    localparam int XS_W     = DOT_W + AXIS_W;
    localparam int ACC_W    = 88;
    localparam int PC_SH    = 32;
    localparam int XS_SH    = 16;
    localparam int RND_SH   = 48;
    localparam int RES_W    = ACC_W - RND_SH;
    localparam int SUM_W    = RES_W + 1;
    localparam int S_TDATA_W = 224;
    localparam int M_TDATA_W = 3 * POS_W;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [OMC_W-1:0]  omc_t;
    typedef logic signed [KOM_W-1:0]  kom_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [DOT_W-1:0]  dot_t;
    typedef logic signed [DHI_W-1:0]  dhi_t;
    typedef logic signed [T1H_W-1:0]  t1h_t;
    typedef logic signed [T1L_W-1:0]  t1l_t;
    typedef logic signed [XS_W-1:0]   xs_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam omc_t ONE_Q16  = omc_t'(65536);
    localparam acc_t RND_HALF = {{(ACC_W-RND_SH){1'b0}}, 1'b1, {(RND_SH-1){1'b0}}};
    localparam pos_t POS_MAX  = 32'sh7fffffff;
    localparam pos_t POS_MIN  = 32'sh80000000;

    typedef struct packed {
        pos_t        shift;
        pos_t  [2:0] pos;
        axis_t       cosine;
        axis_t       sine;
        axis_t [2:0] axis;
    } in_t;

    typedef struct packed {
        kom_t  [2:0] kom;
        dot_t        dot;
        dot_t  [2:0] crs;
        prod_t [2:0] pc;
        axis_t       sine;
        pos_t        shift;
    } geom_t;

    typedef struct packed {
        t1h_t  [2:0] t1h;
        t1l_t  [2:0] t1l;
        prod_t [2:0] pc;
        xs_t   [2:0] xs;
        pos_t        shift;
    } part_t;

endpackage
`default_nettype wire

// ===== src/rvaa_geom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvaa_geom
// Two stages: axis-by-vector, cosine and one-minus-cosine products, then dot and cross products.
// ----------------------------------------------------------------------------
module rvaa_geom
    import rvaa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  in_t   in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output geom_t out_item
);

    logic  s1_valid_reg, s1_valid_next;
    logic  s2_valid_reg, s2_valid_next;
    logic  s1_en, s2_en;
    prod_t pp_reg [3][3];
    prod_t pp_next [3][3];
    prod_t pc_reg [3];
    prod_t pc_next [3];
    kom_t  kom_reg [3];
    kom_t  kom_next [3];
    axis_t sine_reg, sine_next;
    pos_t  shift_reg, shift_next;
    geom_t geom_reg, geom_next;
    omc_t  omc;

    assign s2_en    = !s2_valid_reg || out_ready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    assign s1_valid_next = s1_en ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_en ? s1_valid_reg : s2_valid_reg;

    always_comb
    begin
        omc = ONE_Q16 - omc_t'(in_item.cosine);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pp_next[i][j] = prod_t'(in_item.axis[i]) * prod_t'(in_item.pos[j]);
            end
            pc_next[i]  = prod_t'(in_item.pos[i]) * prod_t'(in_item.cosine);
            kom_next[i] = kom_t'(in_item.axis[i]) * kom_t'(omc);
        end
        sine_next  = in_item.sine;
        shift_next = in_item.shift;
    end

    always_comb
    begin
        geom_next.dot = dot_t'(pp_reg[0][0]) + dot_t'(pp_reg[1][1]) + dot_t'(pp_reg[2][2]);
        geom_next.crs[0] = dot_t'(pp_reg[1][2]) - dot_t'(pp_reg[2][1]);
        geom_next.crs[1] = dot_t'(pp_reg[2][0]) - dot_t'(pp_reg[0][2]);
        geom_next.crs[2] = dot_t'(pp_reg[0][1]) - dot_t'(pp_reg[1][0]);
        for (int i = 0; i < 3; i++)
        begin
            geom_next.kom[i] = kom_reg[i];
            geom_next.pc[i]  = pc_reg[i];
        end
        geom_next.sine  = sine_reg;
        geom_next.shift = shift_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            pp_reg    <= pp_next;
            pc_reg    <= pc_next;
            kom_reg   <= kom_next;
            sine_reg  <= sine_next;
            shift_reg <= shift_next;
        end
        if (s2_en)
        begin
            geom_reg <= geom_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = geom_reg;

endmodule
`default_nettype wire

// ===== src/rvaa_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvaa_mul
// One stage: projection term in two partial products, cross term times sine.
// ----------------------------------------------------------------------------
module rvaa_mul
    import rvaa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  geom_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output part_t out_item
);

    logic  valid_reg, valid_next;
    logic  en;
    part_t part_reg, part_next;
    dhi_t  dot_hi;
    t1l_t  dot_lo;

    assign en         = !valid_reg || out_ready;
    assign in_ready   = en;
    assign valid_next = en ? in_valid : valid_reg;

    always_comb
    begin
        dot_hi = $signed(in_item.dot[DOT_W-1:DLO_W]);
        dot_lo = t1l_t'({1'b0, in_item.dot[DLO_W-1:0]});
        for (int i = 0; i < 3; i++)
        begin
            part_next.t1h[i] = t1h_t'(in_item.kom[i]) * t1h_t'(dot_hi);
            part_next.t1l[i] = t1l_t'(in_item.kom[i]) * dot_lo;
            part_next.xs[i]  = xs_t'(in_item.crs[i]) * xs_t'(in_item.sine);
            part_next.pc[i]  = in_item.pc[i];
        end
        part_next.shift = in_item.shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            part_reg <= part_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = part_reg;

endmodule
`default_nettype wire

// ===== src/rvaa_sum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvaa_sum
// Two stages: full-precision sum with rounding bias, then offset and clamp.
// ----------------------------------------------------------------------------
module rvaa_sum
    import rvaa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  part_t      in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output pos_t [2:0] out_rot,
    output logic       out_sat
);

    logic       s4_valid_reg, s4_valid_next;
    logic       s5_valid_reg, s5_valid_next;
    logic       s4_en, s5_en;
    acc_t       acc_reg [3];
    acc_t       acc_next [3];
    pos_t       shift_reg, shift_next;
    pos_t [2:0] rot_reg, rot_next;
    logic       sat_reg, sat_next;
    sum_t       val;

    assign s5_en    = !s5_valid_reg || out_ready;
    assign s4_en    = !s4_valid_reg || s5_en;
    assign in_ready = s4_en;

    assign s4_valid_next = s4_en ? in_valid : s4_valid_reg;
    assign s5_valid_next = s5_en ? s4_valid_reg : s5_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = (acc_t'(in_item.t1h[i]) <<< DLO_W) + acc_t'(in_item.t1l[i])
                        + (acc_t'(in_item.pc[i]) <<< PC_SH)
                        + (acc_t'(in_item.xs[i]) <<< XS_SH) + RND_HALF;
        end
        shift_next = in_item.shift;
    end

    always_comb
    begin
        sat_next = 1'b0;
        val      = '0;
        for (int i = 0; i < 3; i++)
        begin
            val = sum_t'($signed(acc_reg[i][ACC_W-1:RND_SH])) + sum_t'(shift_reg);
            if (val > sum_t'(POS_MAX))
            begin
                rot_next[i] = POS_MAX;
                sat_next    = 1'b1;
            end
            else if (val < sum_t'(POS_MIN))
            begin
                rot_next[i] = POS_MIN;
                sat_next    = 1'b1;
            end
            else
            begin
                rot_next[i] = val[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_en)
        begin
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
        end
        if (s5_en)
        begin
            rot_reg <= rot_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_rot   = rot_reg;
    assign out_sat   = sat_reg;

endmodule
`default_nettype wire

// ===== src/rotate_vector_about_axis.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rotate_vector_about_axis
// Axis-angle rotation of a Q16.16 vector with offset, saturated output.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata: axis, sine, cosine, pos, shift
// m_*      out  m_tvalid/m_tready  m_tdata: rot_x..rot_z, m_tuser: saturated
//
// One transaction per cycle while m_tready is high, through five register stages
// (products, dot/cross, wide multiplies, sum, round/offset/clamp).
// Each stage holds while the stage after it is full and stalled; empty stages
// absorb an output stall, and once all five are full it drops s_tready in the
// same cycle.
// Reset empties all stages.
// ----------------------------------------------------------------------------
module rotate_vector_about_axis
    import rvaa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // axis_x, axis_y, axis_z, sine, cosine, pos_x, pos_y, pos_z, shift, pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // rot_x, rot_y, rot_z
    output logic [M_TDATA_W-1:0] m_tdata,
    // saturated
    output logic                 m_tuser
);

    in_t        in_item;
    geom_t      geom;
    part_t      part;
    logic       geom_valid, geom_ready;
    logic       part_valid, part_ready;
    pos_t [2:0] rot;

    assign in_item.axis[0] = $signed(s_tdata[17:0]);
    assign in_item.axis[1] = $signed(s_tdata[35:18]);
    assign in_item.axis[2] = $signed(s_tdata[53:36]);
    assign in_item.sine    = $signed(s_tdata[71:54]);
    assign in_item.cosine  = $signed(s_tdata[89:72]);
    assign in_item.pos[0]  = $signed(s_tdata[121:90]);
    assign in_item.pos[1]  = $signed(s_tdata[153:122]);
    assign in_item.pos[2]  = $signed(s_tdata[185:154]);
    assign in_item.shift   = $signed(s_tdata[217:186]);

    rvaa_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (geom_valid),
        .out_ready (geom_ready),
        .out_item  (geom)
    );

    rvaa_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_ready  (geom_ready),
        .in_item   (geom),
        .out_valid (part_valid),
        .out_ready (part_ready),
        .out_item  (part)
    );

    rvaa_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (part_valid),
        .in_ready  (part_ready),
        .in_item   (part),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rot   (rot),
        .out_sat   (m_tuser)
    );

    assign m_tdata = {rot[2], rot[1], rot[0]};

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output stage");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("transaction did not arrive after five cycles");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
        (m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
         m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000 ||
         m_tdata[95:64] == 32'h7fffffff || m_tdata[95:64] == 32'h80000000))
        else $error("saturation flag without a clamped component");

endmodule
`default_nettype wire
